// ----- hw/rtl/cfmb_pkg.sv -----
`timescale 1ns / 1ps

package cfmb_pkg;

   localparam int FRAME_WIDTH_DEF   = 32;
   localparam int FRAME_HEIGHT_DEF  = 32;
   localparam int PATTERN_BYTES_DEF = 32;

   localparam int BLIT_MAX = 16;
   localparam int PITCH1_MAX = 8;

   localparam int FUNC_W   = 3;
   localparam int COORD_W  = 7;
   localparam int SIZE_W   = 6;
   localparam int COLOR_W  = 4;
   localparam int PIDX_W   = 5;
   localparam int PBYTE_W  = 8;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_FILL  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_BLIT  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd2;

   typedef struct packed {
      logic init;
      logic capture;
      logic pat_write;
      logic read;
      logic step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              draw;
      logic              last;
   } stat_type;

endpackage

// ----- hw/rtl/cfmb_if.sv -----
`timescale 1ns / 1ps

interface cfmb_req_if;
   import cfmb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic signed [COORD_W-1:0] x_pos;
   logic signed [COORD_W-1:0] y_pos;
   logic [SIZE_W-1:0]         rect_width;
   logic [SIZE_W-1:0]         rect_height;
   logic [COLOR_W-1:0]        color;
   logic [PIDX_W-1:0]         pattern_index;
   logic [PBYTE_W-1:0]        pattern_byte;

   modport source (
      output valid, func, x_pos, y_pos, rect_width, rect_height, color,
             pattern_index, pattern_byte,
      input  ready
   );

   modport sink (
      input  valid, func, x_pos, y_pos, rect_width, rect_height, color,
             pattern_index, pattern_byte,
      output ready
   );
endinterface

interface cfmb_rsp_if;
   import cfmb_pkg::*;

   logic                valid;
   logic                ready;
   logic [COLOR_W-1:0]  pixel_value;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, pixel_value, status,
      input  ready
   );

   modport sink (
      input  valid, pixel_value, status,
      output ready
   );
endinterface

// ----- hw/rtl/cfmb_ctrl.sv -----
`timescale 1ns / 1ps

module cfmb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  cfmb_pkg::stat_type stat,
   output cfmb_pkg::cmd_type  cmd
);
   import cfmb_pkg::*;

   typedef enum logic [5:0] {
      S_INIT   = 6'b000001,
      S_IDLE   = 6'b000010,
      S_EXEC   = 6'b000100,
      S_DRAW   = 6'b001000,
      S_FLUSH  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      sweep_ff, sweep_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_DRAW;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.draw) begin
               state_in = S_DRAW;
            end else begin
               cmd.pat_write = (stat.func == FUNC_LOAD);
               cmd.read      = (stat.func == FUNC_READ);
               state_in      = S_FINISH;
            end
         end
         S_DRAW: begin
            cmd.step = 1'b1;
            if (stat.last) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            sweep_in = 1'b0;
            state_in = sweep_ff ? S_IDLE : S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/cfmb_dp.sv -----
`timescale 1ns / 1ps

module cfmb_dp #(
   parameter int FRAME_WIDTH   = cfmb_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT  = cfmb_pkg::FRAME_HEIGHT_DEF,
   parameter int PATTERN_BYTES = cfmb_pkg::PATTERN_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cfmb_pkg::cmd_type                  cmd,
   output cfmb_pkg::stat_type                 stat,
   input  logic [cfmb_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [cfmb_pkg::COORD_W-1:0] req_x_pos,
   input  logic signed [cfmb_pkg::COORD_W-1:0] req_y_pos,
   input  logic [cfmb_pkg::SIZE_W-1:0]        req_rect_width,
   input  logic [cfmb_pkg::SIZE_W-1:0]        req_rect_height,
   input  logic [cfmb_pkg::COLOR_W-1:0]       req_color,
   input  logic [cfmb_pkg::PIDX_W-1:0]        req_pattern_index,
   input  logic [cfmb_pkg::PBYTE_W-1:0]       req_pattern_byte,
   output logic [cfmb_pkg::COLOR_W-1:0]       rsp_pixel_value,
   output logic [cfmb_pkg::STATUS_W-1:0]      rsp_status
);
   import cfmb_pkg::*;

   localparam int XW    = $clog2(FRAME_WIDTH);
   localparam int YW    = $clog2(FRAME_HEIGHT);
   localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int PIW   = $clog2(PATTERN_BYTES);

   localparam logic signed [7:0] FW_S = 8'(FRAME_WIDTH);
   localparam logic signed [7:0] FH_S = 8'(FRAME_HEIGHT);
   localparam logic [XW-1:0]     X_MAX = XW'(FRAME_WIDTH - 1);
   localparam logic [YW-1:0]     Y_MAX = YW'(FRAME_HEIGHT - 1);
   localparam logic [AW-1:0]     FW_A = AW'(FRAME_WIDTH);
   localparam logic [5:0]        PB_V = 6'(PATTERN_BYTES);
   localparam logic [SIZE_W-1:0] BLIT_MAX_V = SIZE_W'(BLIT_MAX);
   localparam logic [SIZE_W-1:0] PITCH1_V = SIZE_W'(PITCH1_MAX);

   logic [COLOR_W-1:0] frame_mem [DEPTH];
   logic [PBYTE_W-1:0] pat_mem [PATTERN_BYTES];

   logic signed [7:0] xs, ys, xe, ye, x0, y0, x1, y1, x1m, y1m;
   logic              req_outside, req_too_large, req_empty, req_draw;

   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic                fill_mode_ff, fill_mode_in;
   logic                pitch2_ff, pitch2_in;
   logic signed [7:0]   xs_ff, xs_in, ys_ff, ys_in;
   logic [XW-1:0]       x_first_ff, x_first_in, x_last_ff, x_last_in, xx_ff, xx_in;
   logic [YW-1:0]       y_last_ff, y_last_in, yy_ff, yy_in;
   logic                draw_ff, draw_in;
   logic                outside_ff, outside_in;
   logic                too_large_ff, too_large_in;
   logic [PIDX_W-1:0]   pidx_ff, pidx_in;
   logic [PBYTE_W-1:0]  pbyte_ff, pbyte_in;
   logic                pipe_valid_ff, pipe_valid_in;
   logic [AW-1:0]       pipe_addr_ff, pipe_addr_in;
   logic [2:0]          pipe_bit_ff, pipe_bit_in;
   logic                pipe_biok_ff, pipe_biok_in;
   logic [COLOR_W-1:0]  pixel_ff, pixel_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [PBYTE_W-1:0]  pat_rdata_ff;
   logic [COLOR_W-1:0]  fb_rdata_ff;

   logic [AW-1:0] pix_addr;
   logic [7:0]    col_full, row_full;
   logic [4:0]    bi;
   logic          bi_ok, pidx_ok, x_end, last, fb_we;

   always_comb begin
      xs  = {req_x_pos[COORD_W-1], req_x_pos};
      ys  = {req_y_pos[COORD_W-1], req_y_pos};
      xe  = xs + signed'({2'b00, req_rect_width});
      ye  = ys + signed'({2'b00, req_rect_height});
      x0  = (xs < 0) ? 8'sd0 : xs;
      y0  = (ys < 0) ? 8'sd0 : ys;
      x1  = (xe > FW_S) ? FW_S : xe;
      y1  = (ye > FH_S) ? FH_S : ye;
      x1m = x1 - 8'sd1;
      y1m = y1 - 8'sd1;
      req_outside   = (xs < 0) || (xs >= FW_S) || (ys < 0) || (ys >= FH_S);
      req_too_large = (req_rect_width > BLIT_MAX_V) || (req_rect_height > BLIT_MAX_V);
      req_empty     = (x1 <= x0) || (y1 <= y0);
      req_draw      = (req_func == FUNC_CLEAR) ||
                      (((req_func == FUNC_FILL) ||
                        ((req_func == FUNC_BLIT) && !req_too_large)) && !req_empty);
   end

   assign x_end = (xx_ff == x_last_ff);
   assign last  = x_end && (yy_ff == y_last_ff);

   always_comb begin
      pix_addr = AW'(yy_ff) * FW_A + AW'(xx_ff);
      col_full = 8'(xx_ff) - xs_ff;
      row_full = 8'(yy_ff) - ys_ff;
      bi       = pitch2_ff ? {row_full[3:0], col_full[3]} : {1'b0, row_full[3:0]};
      bi_ok    = (6'(bi) < PB_V);
      pidx_ok  = (6'(pidx_ff) < PB_V);
   end

   always_comb begin
      func_in      = func_ff;
      color_in     = color_ff;
      fill_mode_in = fill_mode_ff;
      pitch2_in    = pitch2_ff;
      xs_in        = xs_ff;
      ys_in        = ys_ff;
      x_first_in   = x_first_ff;
      x_last_in    = x_last_ff;
      y_last_in    = y_last_ff;
      xx_in        = xx_ff;
      yy_in        = yy_ff;
      draw_in      = draw_ff;
      outside_in   = outside_ff;
      too_large_in = too_large_ff;
      pidx_in      = pidx_ff;
      pbyte_in     = pbyte_ff;
      if (cmd.init) begin
         color_in     = '0;
         fill_mode_in = 1'b1;
         x_first_in   = '0;
         x_last_in    = X_MAX;
         y_last_in    = Y_MAX;
         xx_in        = '0;
         yy_in        = '0;
      end else if (cmd.capture) begin
         func_in      = req_func;
         pitch2_in    = (req_rect_width > PITCH1_V);
         xs_in        = xs;
         ys_in        = ys;
         draw_in      = req_draw;
         outside_in   = req_outside;
         too_large_in = req_too_large;
         pidx_in      = req_pattern_index;
         pbyte_in     = req_pattern_byte;
         if (req_func == FUNC_CLEAR) begin
            color_in     = '0;
            fill_mode_in = 1'b1;
            x_first_in   = '0;
            x_last_in    = X_MAX;
            y_last_in    = Y_MAX;
            xx_in        = '0;
            yy_in        = '0;
         end else begin
            color_in     = req_color;
            fill_mode_in = (req_func != FUNC_BLIT);
            x_first_in   = x0[XW-1:0];
            x_last_in    = x1m[XW-1:0];
            y_last_in    = y1m[YW-1:0];
            xx_in        = x0[XW-1:0];
            yy_in        = y0[YW-1:0];
         end
      end else if (cmd.step) begin
         if (x_end) begin
            xx_in = x_first_ff;
            yy_in = yy_ff + 1'b1;
         end else begin
            xx_in = xx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      pipe_valid_in = cmd.step;
      pipe_addr_in  = pix_addr;
      pipe_bit_in   = ~col_full[2:0];
      pipe_biok_in  = bi_ok;
   end

   always_comb begin
      pixel_in  = pixel_ff;
      status_in = status_ff;
      if (cmd.load_rsp) begin
         pixel_in  = ((func_ff == FUNC_READ) && !outside_ff) ? fb_rdata_ff : '0;
         if ((func_ff == FUNC_BLIT) && too_large_ff) begin
            status_in = ST_TOO_LARGE;
         end else if ((func_ff == FUNC_READ) && outside_ff) begin
            status_in = ST_OUTSIDE;
         end else begin
            status_in = ST_OK;
         end
      end
   end

   assign fb_we = pipe_valid_ff &&
                  (fill_mode_ff || (pipe_biok_ff && pat_rdata_ff[pipe_bit_ff]));

   always_ff @(posedge clock) begin
      if (fb_we) begin
         frame_mem[pipe_addr_ff] <= color_ff;
      end
      if (cmd.read && !outside_ff) begin
         fb_rdata_ff <= frame_mem[pix_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pat_write && pidx_ok) begin
         pat_mem[pidx_ff[PIW-1:0]] <= pbyte_ff;
      end
      if (cmd.step && bi_ok) begin
         pat_rdata_ff <= pat_mem[bi[PIW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else begin
         pipe_valid_ff <= pipe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      color_ff     <= color_in;
      fill_mode_ff <= fill_mode_in;
      pitch2_ff    <= pitch2_in;
      xs_ff        <= xs_in;
      ys_ff        <= ys_in;
      x_first_ff   <= x_first_in;
      x_last_ff    <= x_last_in;
      y_last_ff    <= y_last_in;
      xx_ff        <= xx_in;
      yy_ff        <= yy_in;
      draw_ff      <= draw_in;
      outside_ff   <= outside_in;
      too_large_ff <= too_large_in;
      pidx_ff      <= pidx_in;
      pbyte_ff     <= pbyte_in;
      pipe_addr_ff <= pipe_addr_in;
      pipe_bit_ff  <= pipe_bit_in;
      pipe_biok_ff <= pipe_biok_in;
      pixel_ff     <= pixel_in;
      status_ff    <= status_in;
   end

   always_comb begin
      stat.func = func_ff;
      stat.draw = draw_ff;
      stat.last = last;
   end

   assign rsp_pixel_value = pixel_ff;
   assign rsp_status      = status_ff;

endmodule

// ----- hw/rtl/clipped_fill_and_mono_blit_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// req_bus   in         func, x_pos, y_pos, rect_width, rect_height, color,
//                      pattern_index, pattern_byte
// rsp_bus   out        pixel_value, status
//
// One command is in flight at a time; a new beat is taken while a finished
// response still waits in the output register.
// A fill or blit steps through its clipped pixels, since the frame memory
// write port draws one pixel per cycle. A clear sweeps all
// FRAME_WIDTH * FRAME_HEIGHT pixels; load, read and empty or rejected
// commands draw no pixels. After reset, a clearing pass over all
// FRAME_WIDTH * FRAME_HEIGHT pixels runs before the first beat is taken.
// A stalled response holds the block after the next command completes.

module clipped_fill_and_mono_blit_core #(
   parameter int FRAME_WIDTH   = cfmb_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT  = cfmb_pkg::FRAME_HEIGHT_DEF,
   parameter int PATTERN_BYTES = cfmb_pkg::PATTERN_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   cfmb_req_if.sink   req_bus,
   cfmb_rsp_if.source rsp_bus
);
   import cfmb_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cfmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cfmb_dp #(
      .FRAME_WIDTH   (FRAME_WIDTH),
      .FRAME_HEIGHT  (FRAME_HEIGHT),
      .PATTERN_BYTES (PATTERN_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_bus.func),
      .req_x_pos         (req_bus.x_pos),
      .req_y_pos         (req_bus.y_pos),
      .req_rect_width    (req_bus.rect_width),
      .req_rect_height   (req_bus.rect_height),
      .req_color         (req_bus.color),
      .req_pattern_index (req_bus.pattern_index),
      .req_pattern_byte  (req_bus.pattern_byte),
      .rsp_pixel_value   (rsp_bus.pixel_value),
      .rsp_status        (rsp_bus.status)
   );

endmodule
